/* hw/rtl/sbp_pkg.sv */
// Shared types and constants for the Stern-Brocot path block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sbp_pkg;

   // Largest valid operand and the longest walk that is emitted.
   localparam int MAX_OPERAND = 64;
   localparam int MAX_RESULTS = 63;

   // Widths of the operands, cross products and the move counter.
   localparam int OPER_WIDTH  = 7;
   localparam int PROD_WIDTH  = 2 * OPER_WIDTH;
   localparam int COUNT_WIDTH = $clog2(MAX_RESULTS + 1);

   // Depths of the command queue and of the result queue.
   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);

   typedef logic [OPER_WIDTH-1:0] oper_type;

   // What the front decided about one fraction.
   typedef enum logic [1:0] {
      CMD_BAD  = 2'd0,
      CMD_ROOT = 2'd1,
      CMD_WALK = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      oper_type     num;
      oper_type     den;
   } cmd_type;

   // One result beat.
   typedef struct packed {
      logic move_right;
      logic path_empty;
      logic bad_operand;
      logic last_move;
   } rsp_type;

   // Handshake of the result queue's write side.
   typedef struct packed {
      logic    push;
      rsp_type item;
   } rsp_push_type;

endpackage

`default_nettype wire

/* hw/rtl/sbp_front.sv */
// Front of the Stern-Brocot path block: checks and classifies each fraction
// and holds it in a short command queue. Depends on sbp_pkg.
`default_nettype none

module sbp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sbp_pkg::oper_type req_numerator,
   input  wire sbp_pkg::oper_type req_denominator,
   output logic                  cmd_valid,
   output sbp_pkg::cmd_type      cmd,
   input  wire logic             cmd_pop
);
   import sbp_pkg::*;

   localparam oper_type MaxOp = OPER_WIDTH'(MAX_OPERAND);
   localparam logic [CMD_PTR_W:0] CmdFull = (CMD_PTR_W + 1)'(CMD_DEPTH);

   cmd_type              queue_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]   count_ff, count_in;
   logic                 accept;
   logic                 take;
   cmd_type              classified;

   // Sort the fraction into an error, the root itself or a real walk.
   always_comb begin
      classified.num  = req_numerator;
      classified.den  = req_denominator;
      if ((req_numerator == '0) || (req_denominator == '0) ||
          (req_numerator > MaxOp) || (req_denominator > MaxOp)) begin
         classified.kind = CMD_BAD;
      end else if (req_numerator == req_denominator) begin
         classified.kind = CMD_ROOT;
      end else begin
         classified.kind = CMD_WALK;
      end
   end

   assign req_full  = (count_ff == CmdFull);
   assign accept    = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign take      = cmd_pop && cmd_valid;
   assign cmd       = queue_ff[rd_ptr_ff];

   // Pointer and fill count of the command queue.
   always_comb begin
      wr_ptr_in = accept ? CMD_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = take   ? CMD_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sbp_walk.sv */
// Back of the Stern-Brocot path block: walks the tree one move per cycle
// if the result queue has room, writing beats into it. Depends on sbp_pkg.
`default_nettype none

module sbp_walk (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire sbp_pkg::cmd_type   cmd,
   output logic                    cmd_pop,
   input  wire logic               rsp_full,
   output sbp_pkg::rsp_push_type   rsp_wr
);
   import sbp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   localparam logic [COUNT_WIDTH-1:0] MaxMoves = COUNT_WIDTH'(MAX_RESULTS);

   state_type              state_ff, state_in;
   oper_type               tgt_num_ff, tgt_num_in;
   oper_type               tgt_den_ff, tgt_den_in;
   oper_type               left_num_ff, left_num_in;
   oper_type               left_den_ff, left_den_in;
   oper_type               right_num_ff, right_num_in;
   oper_type               right_den_ff, right_den_in;
   oper_type               med_num_ff, med_num_in;
   oper_type               med_den_ff, med_den_in;
   logic [COUNT_WIDTH-1:0] moves_ff, moves_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic                   pend_right_ff, pend_right_in;
   logic [PROD_WIDTH-1:0]  lhs;
   logic [PROD_WIDTH-1:0]  rhs;
   logic                   go_right;

   // Compare the target with the mediant by cross multiplication.
   assign lhs      = PROD_WIDTH'(tgt_num_ff) * PROD_WIDTH'(med_den_ff);
   assign rhs      = PROD_WIDTH'(tgt_den_ff) * PROD_WIDTH'(med_num_ff);
   assign go_right = (lhs > rhs);

   // A move waits in the pending register so that the next
   // comparison can tell whether it ends the path.
   always_comb begin
      state_in      = state_ff;
      tgt_num_in    = tgt_num_ff;
      tgt_den_in    = tgt_den_ff;
      left_num_in   = left_num_ff;
      left_den_in   = left_den_ff;
      right_num_in  = right_num_ff;
      right_den_in  = right_den_ff;
      med_num_in    = med_num_ff;
      med_den_in    = med_den_ff;
      moves_in      = moves_ff;
      pend_valid_in = pend_valid_ff;
      pend_right_in = pend_right_ff;
      cmd_pop       = 1'b0;
      rsp_wr        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_BAD: begin
                     rsp_wr.push             = 1'b1;
                     rsp_wr.item.bad_operand = 1'b1;
                     rsp_wr.item.last_move   = 1'b1;
                  end
                  CMD_ROOT: begin
                     rsp_wr.push            = 1'b1;
                     rsp_wr.item.path_empty = 1'b1;
                     rsp_wr.item.last_move  = 1'b1;
                  end
                  CMD_WALK: begin
                     tgt_num_in    = cmd.num;
                     tgt_den_in    = cmd.den;
                     left_num_in   = OPER_WIDTH'(0);
                     left_den_in   = OPER_WIDTH'(1);
                     right_num_in  = OPER_WIDTH'(1);
                     right_den_in  = OPER_WIDTH'(0);
                     med_num_in    = OPER_WIDTH'(1);
                     med_den_in    = OPER_WIDTH'(1);
                     moves_in      = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_WALK;
                  end
                  default: begin
                     rsp_wr.push             = 1'b1;
                     rsp_wr.item.bad_operand = 1'b1;
                     rsp_wr.item.last_move   = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if ((lhs == rhs) || (moves_ff == MaxMoves)) begin
               // The pending move is the final one of this fraction.
               if (!rsp_full) begin
                  rsp_wr.push            = 1'b1;
                  rsp_wr.item.move_right = pend_right_ff;
                  rsp_wr.item.last_move  = 1'b1;
                  pend_valid_in          = 1'b0;
                  state_in               = ST_IDLE;
               end
            end else if (!pend_valid_ff || !rsp_full) begin
               // Release the previous move and take the next step.
               rsp_wr.push            = pend_valid_ff;
               rsp_wr.item.move_right = pend_right_ff;
               if (go_right) begin
                  left_num_in = med_num_ff;
                  left_den_in = med_den_ff;
                  med_num_in  = OPER_WIDTH'(med_num_ff + right_num_ff);
                  med_den_in  = OPER_WIDTH'(med_den_ff + right_den_ff);
               end else begin
                  right_num_in = med_num_ff;
                  right_den_in = med_den_ff;
                  med_num_in   = OPER_WIDTH'(med_num_ff + left_num_ff);
                  med_den_in   = OPER_WIDTH'(med_den_ff + left_den_ff);
               end
               pend_valid_in = 1'b1;
               pend_right_in = go_right;
               moves_in      = COUNT_WIDTH'(moves_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Walk data; the bounds restart from the root for each fraction.
   always_ff @(posedge clock) begin
      tgt_num_ff    <= tgt_num_in;
      tgt_den_ff    <= tgt_den_in;
      left_num_ff   <= left_num_in;
      left_den_ff   <= left_den_in;
      right_num_ff  <= right_num_in;
      right_den_ff  <= right_den_in;
      med_num_ff    <= med_num_in;
      med_den_ff    <= med_den_in;
      moves_ff      <= moves_in;
      pend_right_ff <= pend_right_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/sbp_rsp_queue.sv */
// Result queue of the Stern-Brocot path block: holds finished result beats
// until the consumer pops them. Depends on sbp_pkg.
`default_nettype none

module sbp_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sbp_pkg::rsp_push_type rsp_wr,
   output logic                       full,
   output logic                       empty,
   input  wire logic                  pop,
   output sbp_pkg::rsp_type           head
);
   import sbp_pkg::*;

   localparam logic [RSP_PTR_W:0] RspFull = (RSP_PTR_W + 1)'(RSP_DEPTH);

   rsp_type              queue_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W:0]   count_ff, count_in;
   logic                 put;
   logic                 take;

   assign full  = (count_ff == RspFull);
   assign empty = (count_ff == '0);
   assign put   = rsp_wr.push && !full;
   assign take  = pop && !empty;
   assign head  = queue_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_comb begin
      wr_ptr_in = put  ? RSP_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = take ? RSP_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (put && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !put) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage of the result beats.
   always_ff @(posedge clock) begin
      if (put) begin
         queue_ff[wr_ptr_ff] <= rsp_wr.item;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/stern_brocot_path.sv */
// Top level of the Stern-Brocot path block: front, walk engine and result
// queue. Depends on sbp_pkg, sbp_front, sbp_walk and sbp_rsp_queue.
`default_nettype none

// Push a fraction numerator/denominator (1 to 64 each) and pop its path from
// the root 1/1 of the Stern-Brocot tree, one result beat per move, R as
// move_right = 1 and L as 0, with last_move set on the final beat. A fraction
// equal to the root (n equal to d) yields one beat with path_empty set, and
// a zero or oversized operand one beat with bad_operand set. Non-reduced
// fractions end at their reduced node. The walk engine loads a fraction,
// then makes one move per cycle while the result queue has room, and ends
// with a closing step that writes the last beat; an error or root fraction
// is answered from the idle state alone. The engine's single cross-multiply
// compare sets this rate. A two-entry command queue in front and a four-entry
// result queue behind let pushes and pops run independently of the walk.
module stern_brocot_path (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire sbp_pkg::oper_type req_numerator,
   input  wire sbp_pkg::oper_type req_denominator,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic                   rsp_move_right,
   output logic                   rsp_path_empty,
   output logic                   rsp_bad_operand,
   output logic                   rsp_last_move
);
   import sbp_pkg::*;

   logic         cmd_valid;
   cmd_type      cmd;
   logic         cmd_pop;
   logic         rq_full;
   rsp_push_type rsp_wr;
   rsp_type      head;

   // Front: classification and command queue.
   sbp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // Back: the tree walk.
   sbp_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rq_full),
      .rsp_wr    (rsp_wr)
   );

   // Result beats waiting for the consumer.
   sbp_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .rsp_wr (rsp_wr),
      .full   (rq_full),
      .empty  (rsp_empty),
      .pop    (rsp_pop),
      .head   (head)
   );

   assign rsp_move_right  = head.move_right;
   assign rsp_path_empty  = head.path_empty;
   assign rsp_bad_operand = head.bad_operand;
   assign rsp_last_move   = head.last_move;

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for stern_brocot_path: drives fractions, predicts each
// tree path and compares every result beat. Depends on sbp_pkg and the block.
`default_nettype none

module tb;

   import sbp_pkg::*;

   localparam int RANDOM_FRACTIONS = 350;
   localparam int CYCLE_LIMIT      = 400_000;
   localparam int DRAIN_CYCLES     = 100;
   localparam oper_type MAX_OP     = OPER_WIDTH'(MAX_OPERAND);

   typedef logic [2*OPER_WIDTH-1:0] product_type;

   // Predicts the path of each accepted fraction and checks the result beats.
   class path_scoreboard;
      rsp_type  path_beats[$];
      int       failures;
      oper_type lo_num, lo_den, hi_num, hi_den, med_num, med_den;

      function new();
         failures = 0;
         load_root();
      endfunction

      function void load_root();
         lo_num  = 7'd0;
         lo_den  = 7'd1;
         hi_num  = 7'd1;
         hi_den  = 7'd0;
         med_num = 7'd1;
         med_den = 7'd1;
      endfunction

      // Walks the tree for one accepted fraction and queues its beats.
      function void note_fraction(oper_type num, oper_type den);
         rsp_type     beat;
         product_type lhs, rhs;
         bit          go_right;
         int          moves;
         beat  = '0;
         moves = 0;
         if (num == '0 || den == '0 || num > MAX_OP || den > MAX_OP) begin
            beat.bad_operand = 1'b1;
            beat.last_move   = 1'b1;
            path_beats.push_back(beat);
            return;
         end
         load_root();
         if (num == den) begin
            beat.path_empty = 1'b1;
            beat.last_move  = 1'b1;
            path_beats.push_back(beat);
            return;
         end
         while (moves < MAX_RESULTS) begin
            lhs = product_type'(num) * product_type'(med_den);
            rhs = product_type'(den) * product_type'(med_num);
            if (lhs == rhs)
               break;
            go_right = lhs > rhs;
            if (go_right) begin
               lo_num  = med_num;
               lo_den  = med_den;
               med_num = med_num + hi_num;
               med_den = med_den + hi_den;
            end else begin
               hi_num  = med_num;
               hi_den  = med_den;
               med_num = med_num + lo_num;
               med_den = med_den + lo_den;
            end
            beat            = '0;
            beat.move_right = go_right;
            path_beats.push_back(beat);
            moves++;
         end
         // The final move of the walk closes the fraction.
         path_beats[path_beats.size()-1].last_move = 1'b1;
      endfunction

      // Compares one popped beat with the oldest predicted beat.
      function void check_beat(rsp_type actual);
         rsp_type want;
         if (path_beats.size() == 0) begin
            $display("%0t: unexpected beat %b, nothing predicted", $time, actual);
            failures++;
            return;
         end
         want = path_beats.pop_front();
         if (actual.move_right !== want.move_right) begin
            $display("%0t: move_right expected %b actual %b", $time,
                     want.move_right, actual.move_right);
            failures++;
         end
         if (actual.path_empty !== want.path_empty) begin
            $display("%0t: path_empty expected %b actual %b", $time,
                     want.path_empty, actual.path_empty);
            failures++;
         end
         if (actual.bad_operand !== want.bad_operand) begin
            $display("%0t: bad_operand expected %b actual %b", $time,
                     want.bad_operand, actual.bad_operand);
            failures++;
         end
         if (actual.last_move !== want.last_move) begin
            $display("%0t: last_move expected %b actual %b", $time,
                     want.last_move, actual.last_move);
            failures++;
         end
      endfunction

      function int pending();
         return path_beats.size();
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_push = 1'b0;
   oper_type req_numerator = '0;
   oper_type req_denominator = '0;
   logic     rsp_pop = 1'b0;
   logic     req_full, rsp_empty;
   logic     rsp_move_right, rsp_path_empty, rsp_bad_operand, rsp_last_move;

   path_scoreboard paths = new();
   int             cycle_count = 0;
   bit             send_steady = 1'b0;
   bit             pop_steady = 1'b0;

   stern_brocot_path dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_move_right  (rsp_move_right),
      .rsp_path_empty  (rsp_path_empty),
      .rsp_bad_operand (rsp_bad_operand),
      .rsp_last_move   (rsp_last_move)
   );

   always #2 clock = ~clock;

   // Draws the idle cycles before the next push or pop; steady stretches use none.
   function automatic int draw_gap(inout bit steady);
      if ($urandom_range(0, 29) == 0)
         steady = ~steady;
      return steady ? 0 : int'($urandom_range(0, 4));
   endfunction

   // Pushes one fraction and notes it once the block has taken it.
   task automatic send_fraction(input oper_type num, input oper_type den);
      int gap;
      gap = draw_gap(send_steady);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_numerator   <= num;
      req_denominator <= den;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      paths.note_fraction(num, den);
   endtask

   // Mostly valid fractions, some on the root, some with a bad operand.
   task automatic send_random_fraction();
      oper_type num, den;
      int       pick;
      pick = int'($urandom_range(0, 99));
      num  = oper_type'($urandom_range(1, MAX_OPERAND));
      den  = oper_type'($urandom_range(1, MAX_OPERAND));
      if (pick < 8) begin
         den = num;
      end else if (pick < 14) begin
         if ($urandom_range(0, 1))
            num = '0;
         else
            den = '0;
      end else if (pick < 20) begin
         if ($urandom_range(0, 1))
            num = oper_type'($urandom_range(MAX_OPERAND + 1, 127));
         else
            den = oper_type'($urandom_range(MAX_OPERAND + 1, 127));
      end
      send_fraction(num, den);
   endtask

   // Pops result beats for the whole run and hands each to the scoreboard.
   task automatic pop_results();
      int      gap;
      rsp_type beat;
      forever begin
         gap = draw_gap(pop_steady);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty)
            @(posedge clock);
         beat.move_right  = rsp_move_right;
         beat.path_empty  = rsp_path_empty;
         beat.bad_operand = rsp_bad_operand;
         beat.last_move   = rsp_last_move;
         paths.check_beat(beat);
      end
   endtask

   // Ends a run that hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         pop_results();
      join_none

      // Directed fractions: bad operands, root cases, longest and odd paths.
      send_fraction(7'd0, 7'd0);
      send_fraction(7'd0, 7'd5);
      send_fraction(7'd5, 7'd0);
      send_fraction(7'd65, 7'd1);
      send_fraction(7'd1, 7'd65);
      send_fraction(7'd127, 7'd127);
      send_fraction(7'd1, 7'd1);
      send_fraction(7'd3, 7'd3);
      send_fraction(7'd64, 7'd64);
      send_fraction(7'd64, 7'd1);
      send_fraction(7'd1, 7'd64);
      send_fraction(7'd63, 7'd64);
      send_fraction(7'd64, 7'd63);
      send_fraction(7'd2, 7'd4);
      send_fraction(7'd1, 7'd2);
      send_fraction(7'd2, 7'd1);
      send_fraction(7'd127, 7'd3);
      send_fraction(7'd3, 7'd127);
      send_fraction(7'd5, 7'd8);
      send_fraction(7'd8, 7'd5);
      send_fraction(7'd37, 7'd59);
      send_fraction(7'd42, 7'd12);

      repeat (RANDOM_FRACTIONS)
         send_random_fraction();
      req_push <= 1'b0;

      // Let every predicted beat come out, then watch for strays.
      while (paths.pending() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (paths.failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
